// ----- rtl/rrw_pkg.sv -----
// Shared types and constants of the receive reorder window
`timescale 1ns / 1ps
`default_nettype none

package rrw_pkg;

  // default number of physical slots
  localparam int MaxSlotsDef = 64;
  // field widths
  localparam int HandleBits = 16;
  localparam int SeqBits = 32;
  localparam int WsBits = 7;
  // window_size after reset
  localparam logic [WsBits-1:0] WindowSizeRst = 7'd5;

  // register address of window_size
  localparam logic [1:0] AddrWindowSize = 2'd0;

  // item opcodes
  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    StPlaced    = 3'd0,
    StDuplicate = 3'd1,
    StBeyond    = 3'd2,
    StStale     = 3'd3,
    StBlocked   = 3'd4,
    StRemoved   = 3'd5,
    StNothing   = 3'd6
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    CtlIdle,
    CtlEval,
    CtlScan,
    CtlDone
  } ctl_state_t;

  // input item
  typedef struct packed {
    logic                  opcode;
    logic [SeqBits-1:0]    seq_in;
    logic [HandleBits-1:0] handle_in;
  } in_item_t;

  // result item
  typedef struct packed {
    status_t               status;
    logic [HandleBits-1:0] handle_out;
    logic [SeqBits-1:0]    next_expected;
    logic [WsBits-1:0]     advertised_window;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/receive_reorder_window.sv -----
// Receive reorder window: slot store, handle memory and scan sequencer
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// in_       input      in_valid / in_stall   rrw_pkg::in_item_t
// out_      output     out_valid / out_stall rrw_pkg::out_item_t
// apb       input      psel/penable/pwrite   window_size at byte address 0
//
// an item passes through evaluate, the scan steps (each step that finds a present slot
// extends the run, the last one finds its end), deliver, and back to idle, where the
// next item is accepted; the result is valid once deliver has loaded it. The scan
// counter over the present bits sets how far the run grows: not at all for remove and
// drops, up to the effective window after a fill of a hole
// reset (rst_n low, synchronous) empties the window, base 1, window_size 5
// a window_size write drops every buffered handle and clears the in-order run
// a result waits in the output register while out_stall is high; the next item
// is already taken and holds in the deliver step until the register frees

module receive_reorder_window #(
  parameter int MAX_SLOTS = rrw_pkg::MaxSlotsDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rrw_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rrw_pkg::out_item_t     out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [1:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int WW = (CNT_W > rrw_pkg::WsBits) ? CNT_W : rrw_pkg::WsBits;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_SLOTS - 1);

  // registers
  rrw_pkg::ctl_state_t               state_r, state_nxt;
  logic [rrw_pkg::WsBits-1:0]        window_size_r, window_size_nxt;
  logic [MAX_SLOTS-1:0]              present_r, present_nxt;
  logic [rrw_pkg::SeqBits-1:0]       base_r, base_nxt;
  logic [IDX_W-1:0]                  head_r, head_nxt;
  logic [CNT_W-1:0]                  run_r, run_nxt;
  logic [CNT_W-1:0]                  scan_r, scan_nxt;
  rrw_pkg::in_item_t                 item_r, item_nxt;
  rrw_pkg::status_t                  status_r, status_nxt;
  logic                              out_valid_r, out_valid_nxt;
  rrw_pkg::out_item_t                out_r, out_nxt;

  // handle memory
  logic [rrw_pkg::HandleBits-1:0]    handle_mem [MAX_SLOTS];
  logic [rrw_pkg::HandleBits-1:0]    rd_data_r;
  logic                              mem_we, mem_re;
  logic [IDX_W-1:0]                  mem_addr;

  // shared datapath
  logic                              cfg_wr;
  logic [WW-1:0]                     ws_ext, w_eff;
  logic [rrw_pkg::SeqBits-1:0]       off;
  logic [CNT_W-1:0]                  phys_off;
  logic [CNT_W:0]                    phys_sum;
  logic [IDX_W-1:0]                  phys_idx;

  assign pready = 1'b1;
  assign prdata = {{(32 - rrw_pkg::WsBits){1'b0}}, window_size_r};
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == rrw_pkg::AddrWindowSize);

  assign in_stall  = (state_r != rrw_pkg::CtlIdle);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // effective window, clamped to 1..MAX_SLOTS
  always_comb begin
    ws_ext = WW'(window_size_r);
    priority if (ws_ext == '0) begin
      w_eff = WW'(1);
    end else if (ws_ext > WW'(MAX_SLOTS)) begin
      w_eff = WW'(MAX_SLOTS);
    end else begin
      w_eff = ws_ext;
    end
  end

  // offset of the item's sequence number from the base
  assign off = item_r.seq_in - base_r;

  // shared slot index unit: head plus offset, modulo the slot count
  always_comb begin
    if (state_r == rrw_pkg::CtlScan) begin
      phys_off = scan_r;
    end else if (item_r.opcode == rrw_pkg::OpInsert) begin
      phys_off = off[CNT_W-1:0];
    end else begin
      phys_off = '0;
    end
    phys_sum = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(phys_off);
    if (phys_sum >= (CNT_W + 1)'(MAX_SLOTS)) begin
      phys_idx = IDX_W'(phys_sum - (CNT_W + 1)'(MAX_SLOTS));
    end else begin
      phys_idx = IDX_W'(phys_sum);
    end
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt       = state_r;
    window_size_nxt = window_size_r;
    present_nxt     = present_r;
    base_nxt        = base_r;
    head_nxt        = head_r;
    run_nxt         = run_r;
    scan_nxt        = scan_r;
    item_nxt        = item_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_valid_r;
    out_nxt         = out_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = phys_idx;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      rrw_pkg::CtlIdle: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = rrw_pkg::CtlEval;
        end
      end
      rrw_pkg::CtlEval: begin
        scan_nxt  = run_r;
        state_nxt = rrw_pkg::CtlScan;
        if (item_r.opcode == rrw_pkg::OpInsert) begin
          priority if (WW'(run_r) == w_eff) begin
            status_nxt = rrw_pkg::StBlocked;
          end else if (off[rrw_pkg::SeqBits-1]) begin
            status_nxt = rrw_pkg::StStale;
          end else if (off >= rrw_pkg::SeqBits'(w_eff)) begin
            status_nxt = rrw_pkg::StBeyond;
          end else if (present_r[phys_idx]) begin
            status_nxt = rrw_pkg::StDuplicate;
          end else begin
            status_nxt            = rrw_pkg::StPlaced;
            present_nxt[phys_idx] = 1'b1;
            mem_we                = 1'b1;
          end
        end else begin
          if (present_r[phys_idx]) begin
            // pop the head; the rest of the run stays in order
            status_nxt            = rrw_pkg::StRemoved;
            present_nxt[phys_idx] = 1'b0;
            mem_re                = 1'b1;
            head_nxt              = (head_r == LastIdx) ? '0 : head_r + IDX_W'(1);
            base_nxt              = base_r + rrw_pkg::SeqBits'(1);
            run_nxt               = run_r - CNT_W'(1);
            scan_nxt              = run_r - CNT_W'(1);
          end else begin
            status_nxt = rrw_pkg::StNothing;
          end
        end
      end
      rrw_pkg::CtlScan: begin
        // one slot per cycle extends the in-order run
        if ((WW'(scan_r) < w_eff) && present_r[phys_idx]) begin
          scan_nxt = scan_r + CNT_W'(1);
        end else begin
          run_nxt   = scan_r;
          state_nxt = rrw_pkg::CtlDone;
        end
      end
      rrw_pkg::CtlDone: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_nxt.status               = status_r;
          out_nxt.handle_out           = (status_r == rrw_pkg::StRemoved) ? rd_data_r : '0;
          out_nxt.next_expected        = base_r + rrw_pkg::SeqBits'(run_r);
          out_nxt.advertised_window    = rrw_pkg::WsBits'(w_eff - WW'(run_r));
          state_nxt                    = rrw_pkg::CtlIdle;
        end
      end
      default: begin
        state_nxt = rrw_pkg::CtlIdle;
      end
    endcase

    // resize drops all buffered handles
    if (cfg_wr) begin
      window_size_nxt = pwdata[rrw_pkg::WsBits-1:0];
      present_nxt     = '0;
      run_nxt         = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rrw_pkg::CtlIdle;
      window_size_r <= rrw_pkg::WindowSizeRst;
      present_r     <= '0;
      base_r        <= rrw_pkg::SeqBits'(1);
      head_r        <= '0;
      run_r         <= '0;
      scan_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      window_size_r <= window_size_nxt;
      present_r     <= present_nxt;
      base_r        <= base_nxt;
      head_r        <= head_nxt;
      run_r         <= run_nxt;
      scan_r        <= scan_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  // handle memory, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      handle_mem[mem_addr] <= item_r.handle_in;
    end
    if (mem_re) begin
      rd_data_r <= handle_mem[mem_addr];
    end
  end

  // the in-order run never exceeds the window
  a_run_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(run_r) <= w_eff)
    else $error("in-order run beyond window");

  // between items the head slot is present exactly when the run is not empty
  a_head_matches_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrw_pkg::CtlIdle) |-> ((run_r != '0) == present_r[head_r]))
    else $error("head slot and in-order run disagree");

  // a resize leaves an empty window
  a_resize_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> ((present_r == '0) && (run_r == '0)))
    else $error("resize left buffered handles");

endmodule

`default_nettype wire

// ----- tb/tb_receive_reorder_window.sv -----
// Self-checking testbench of the receive reorder window: directed and random items
`timescale 1ns / 1ps

module tb_receive_reorder_window;

  localparam int ClkHalf = 2;
  localparam int RstCycles = 12;
  localparam int CycleLimit = 1000000;
  // worst case scan of one item plus accept, evaluate and deliver
  localparam int TailCycles = rrw_pkg::MaxSlotsDef + 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rrw_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rrw_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // idling on both channels is enabled while this is set
  bit gaps_on = 1'b0;
  int fail_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  rrw_pkg::out_item_t pending_results[$];

  // window state as the testbench sees it
  logic slot_full[rrw_pkg::MaxSlotsDef];
  logic [rrw_pkg::HandleBits-1:0] slot_buf[rrw_pkg::MaxSlotsDef];
  logic [rrw_pkg::SeqBits-1:0] win_base;
  logic [5:0] win_head;
  logic [rrw_pkg::WsBits-1:0] win_size_reg;

  receive_reorder_window u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #ClkHalf clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("** receive_reorder_window: FAILED **");
      $finish;
    end
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // effective window: register clamped to 1 .. slot count
  function automatic int unsigned eff_window();
    int unsigned w;
    w = 32'(win_size_reg);
    if (w < 1) w = 1;
    if (w > rrw_pkg::MaxSlotsDef) w = rrw_pkg::MaxSlotsDef;
    return w;
  endfunction

  function automatic int unsigned slot_of(input int unsigned off);
    return (win_head + off) % rrw_pkg::MaxSlotsDef;
  endfunction

  // count of present slots from the head onward
  function automatic int unsigned inorder_run(input int unsigned w);
    int unsigned n;
    n = 0;
    while (n < w && slot_full[slot_of(n)]) n++;
    return n;
  endfunction

  function automatic void window_reset();
    foreach (slot_full[i]) begin
      slot_full[i] = 1'b0;
      slot_buf[i] = '0;
    end
    win_base = 32'd1;
    win_head = '0;
    win_size_reg = rrw_pkg::WindowSizeRst;
  endfunction

  function automatic void window_resize(input logic [rrw_pkg::WsBits-1:0] val);
    win_size_reg = val;
    foreach (slot_full[i]) slot_full[i] = 1'b0;
  endfunction

  // applies one item to the window and returns the result it should give
  function automatic rrw_pkg::out_item_t window_step(input rrw_pkg::in_item_t it);
    rrw_pkg::out_item_t res;
    int unsigned w;
    int unsigned run;
    int unsigned p;
    logic [rrw_pkg::SeqBits-1:0] off;
    w = eff_window();
    res = '0;
    if (it.opcode == rrw_pkg::OpInsert) begin
      off = it.seq_in - win_base;
      if (inorder_run(w) == w) begin
        res.status = rrw_pkg::StBlocked;
      end else if (off[rrw_pkg::SeqBits-1]) begin
        res.status = rrw_pkg::StStale;
      end else if (off >= w) begin
        res.status = rrw_pkg::StBeyond;
      end else if (slot_full[slot_of(off)]) begin
        res.status = rrw_pkg::StDuplicate;
      end else begin
        p = slot_of(off);
        slot_full[p] = 1'b1;
        slot_buf[p] = it.handle_in;
        res.status = rrw_pkg::StPlaced;
      end
    end else begin
      p = slot_of(0);
      if (slot_full[p]) begin
        res.handle_out = slot_buf[p];
        slot_full[p] = 1'b0;
        win_head = win_head + 1'b1;
        win_base = win_base + 1;
        res.status = rrw_pkg::StRemoved;
      end else begin
        res.status = rrw_pkg::StNothing;
      end
    end
    run = inorder_run(w);
    res.next_expected = win_base + run;
    res.advertised_window = rrw_pkg::WsBits'(w - run);
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    rrw_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t status: expected %s, got %0d", $time, want.status.name(),
                   out_data.status);
          fail_count++;
        end
        if (out_data.handle_out !== want.handle_out) begin
          $display("%0t handle_out: expected %h, got %h", $time, want.handle_out,
                   out_data.handle_out);
          fail_count++;
        end
        if (out_data.next_expected !== want.next_expected) begin
          $display("%0t next_expected: expected %h, got %h", $time, want.next_expected,
                   out_data.next_expected);
          fail_count++;
        end
        if (out_data.advertised_window !== want.advertised_window) begin
          $display("%0t advertised_window: expected %0d, got %0d", $time,
                   want.advertised_window, out_data.advertised_window);
          fail_count++;
        end
      end
    end
  end

  // sends one item, with an optional gap before it
  task automatic send_item(input rrw_pkg::in_item_t it);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(window_step(it));
  endtask

  task automatic send_insert(input logic [rrw_pkg::SeqBits-1:0] seq,
                             input logic [rrw_pkg::HandleBits-1:0] h);
    rrw_pkg::in_item_t it;
    it.opcode = rrw_pkg::OpInsert;
    it.seq_in = seq;
    it.handle_in = h;
    send_item(it);
  endtask

  task automatic send_remove();
    rrw_pkg::in_item_t it;
    it.opcode = rrw_pkg::OpRemove;
    it.seq_in = $urandom;
    it.handle_in = rrw_pkg::HandleBits'($urandom);
    send_item(it);
  endtask

  // stops sending and waits until every result has come
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // APB write of window_size while idle, then read back
  task automatic set_window(input logic [rrw_pkg::WsBits-1:0] val);
    logic [31:0] rd;
    wait_drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= rrw_pkg::AddrWindowSize;
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    window_resize(val);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[rrw_pkg::WsBits-1:0] !== val) begin
      $display("%0t window_size readback: expected %0d, got %0d", $time, val,
               rd[rrw_pkg::WsBits-1:0]);
      fail_count++;
    end
  endtask

  // removes and inserts: mostly near the window, some stale numbers and fully random noise
  function automatic rrw_pkg::in_item_t random_item();
    rrw_pkg::in_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.handle_in = rrw_pkg::HandleBits'($urandom);
    it.seq_in = $urandom;
    if (r < 40) begin
      it.opcode = rrw_pkg::OpRemove;
    end else begin
      it.opcode = rrw_pkg::OpInsert;
      if (r < 88) it.seq_in = win_base + $urandom_range(0, eff_window() + 1);
      else if (r < 94) it.seq_in = win_base - $urandom_range(1, 100);
    end
    return it;
  endfunction

  task automatic send_random(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      send_item(random_item());
    end
  endtask

  // empty window after reset: every status, handle extremes, wrap of the offset
  task automatic test_reset_window();
    send_remove();
    send_insert(32'h0000_0000, 16'h1111);
    send_insert(32'd6, 16'h2222);
    send_insert(32'h8000_0000, 16'h3333);
    send_insert(32'h8000_0001, 16'h4444);
    send_insert(32'hFFFF_FFFF, 16'h5555);
    send_insert(32'd3, 16'hFFFF);
    send_insert(32'd3, 16'h0000);
    send_remove();
    send_insert(32'd1, 16'h0000);
    send_insert(32'd2, 16'hA5A5);
    send_insert(32'd4, 16'h5A5A);
    send_insert(32'd5, 16'h8001);
    send_insert(32'd3, 16'h7FFE);
    repeat (6) send_remove();
  endtask

  // resize drops buffered handles and clamps out-of-range sizes
  task automatic test_resize();
    send_insert(win_base, 16'hBEEF);
    set_window(7'd1);
    send_remove();
    send_insert(win_base, 16'hCAFE);
    send_insert(win_base + 1, 16'hF00D);
    send_remove();
    send_insert(win_base - 1, 16'h0001);
    set_window(7'd0);
    send_insert(win_base + 1, 16'h0002);
    send_insert(win_base, 16'h0003);
    send_insert(win_base, 16'h0004);
    set_window(7'd127);
    send_insert(win_base + 63, 16'h0005);
    send_insert(win_base + 64, 16'h0006);
    set_window(7'd64);
    send_insert(win_base + 63, 16'h0007);
    send_insert(win_base, 16'h0008);
    send_remove();
    set_window(7'd2);
    send_remove();
  endtask

  task automatic test_random_traffic(input logic [rrw_pkg::WsBits-1:0] wsize,
                                     input int n_items);
    set_window(wsize);
    send_random(n_items);
  endtask

  // sender holds off until the window has answered everything
  task automatic test_sender_pause();
    gaps_on = 1'b1;
    send_random(30);
    wait_drain();
    send_random(30);
  endtask

  // closing stretch: random items, then a run with no idling on either side
  task automatic test_quiet_tail();
    set_window(7'($urandom_range(1, 64)));
    send_random(40);
    gaps_on = 1'b0;
    for (int i = 0; i < 120; i++) send_item(random_item());
  endtask

  initial begin
    window_reset();
    repeat (RstCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_window();
    test_resize();
    test_random_traffic(7'd5, 200);
    test_random_traffic(7'd1, 150);
    test_random_traffic(7'd64, 250);
    test_random_traffic(7'd127, 150);
    test_random_traffic(7'd0, 100);
    test_random_traffic(7'd3, 200);
    test_random_traffic(7'($urandom_range(2, 63)), 200);
    test_sender_pause();
    test_quiet_tail();
    wait_drain();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("** receive_reorder_window: PASSED **");
    end else begin
      $display("** receive_reorder_window: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rrw_pkg.sv
rtl/receive_reorder_window.sv
tb/tb_receive_reorder_window.sv
